@@ src/ikht_pkg.sv @@
// Shared types and constants for the inode key hash table.
// Holds the request/response payload structs, the record layout and the FNV-1a constants.
package ikht_pkg;

   // 64-bit FNV-1a offset basis and prime, the prime split into 32-bit halves.
   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam logic [31:0] PRIME_LO  = 32'h0000_01B3;
   localparam logic [31:0] PRIME_HI  = 32'h0000_0100;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [31:0] device_id;
      logic [63:0] inode_number;
      logic [31:0] path_id;
   } req_type;

   typedef struct packed {
      logic [9:0]  record_index;
      logic        is_new;
      logic [15:0] prior_count;
      logic [31:0] first_path;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] device;
      logic [63:0] inode;
      logic [31:0] first_path;
      logic [15:0] count;
   } record_type;

endpackage

@@ src/inode_key_hash_table_top.sv @@
// Top level of the inode key hash table: hashing sequencer, linear probe and record store.
// Depends on ikht_pkg, ikht_ram and ikht_fnv_hash.

// This block detects repeated (device, inode) keys. Each request carries a device id,
// an inode number and a path id. The key is hashed with 64-bit FNV-1a and the low
// bits of the hash pick a slot in a table of SLOTS entries, which is probed linearly
// with wrap-around. On a hit the response gives the record index, the path id of the
// first sighting and the number of earlier sightings, and the stored count is then
// bumped, saturating at 65535. On a miss a new record is created, with is_new set;
// once the records fill half of the slots a new key is refused with status 1 and all
// other response fields zero, while keys already present are still served. After
// reset the block clears every entry of the slot table, and accepts no request during
// that sweep. A request is hashed first and then probed slot by slot, each occupied
// slot passed over adding a further probe step; a waiting response that is not taken
// holds the sequencer until it is taken. The hash dominates the time of a request: its
// two multiplications by the prime run as eight steps of a single shared 32x32
// multiplier. Each probe step costs one read of the slot memory and, when the slot is
// occupied, one read of the record memory. The block works on one request at a time,
// but a new request may be accepted while the previous response still waits in the
// output register.
module inode_key_hash_table_top #(
   parameter int SLOTS = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ikht_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ikht_pkg::rsp_type rsp_payload
);

   localparam int SW      = $clog2(SLOTS);
   localparam int RW      = SW - 1;
   localparam int REC_CAP = SLOTS / 2;
   localparam int REC_W   = $bits(ikht_pkg::record_type);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_HASH     = 6'b000100,
      ST_SLOT_RD  = 6'b001000,
      ST_SLOT_CHK = 6'b010000,
      ST_REC_CHK  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   ikht_pkg::req_type    key_ff, key_in;
   logic [SW-1:0]        probe_ff, probe_in;
   logic [RW-1:0]        rec_addr_ff, rec_addr_in;
   logic [SW-1:0]        used_ff, used_in;
   logic [SW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ikht_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 hash_start;
   logic                 hash_done;
   logic [63:0]          hash_value;

   logic                 slot_wr_en;
   logic [SW-1:0]        slot_wr_addr;
   logic [SW-1:0]        slot_wr_data;
   logic                 slot_rd_en;
   logic [SW-1:0]        slot_rd_data;
   logic [SW-1:0]        slot_dec;

   logic                 rec_wr_en;
   logic [RW-1:0]        rec_wr_addr;
   ikht_pkg::record_type rec_wr_data;
   logic                 rec_rd_en;
   ikht_pkg::record_type rec_rd_data;

   logic                 rsp_free;
   logic                 rsp_load;
   logic                 table_full;
   logic                 key_match;
   logic [15:0]          count_next;
   logic [RW-1:0]        idx_sel;
   logic [RW+9:0]        idx_ext;

   // The unit hashes the device id straight from the request and the inode from the
   // captured key, which holds for the whole request.
   ikht_fnv_hash u_hash (
      .clock        (clock),
      .reset        (reset),
      .start        (hash_start),
      .device_id    (req_payload.device_id),
      .inode_number (key_ff.inode_number),
      .done         (hash_done),
      .hash         (hash_value)
   );

   // Slot table: zero means empty, otherwise it holds the record index plus one.
   ikht_ram #(
      .WIDTH (SW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (probe_ff),
      .rd_data (slot_rd_data)
   );

   // Record store: key, first path id and sighting count packed in one word, so a hit
   // rewrites the whole record with its bumped count.
   ikht_ram #(
      .WIDTH (REC_W),
      .DEPTH (REC_CAP)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (rec_addr_in),
      .rd_data (rec_rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign hash_start  = req_valid && (state_ff == ST_IDLE);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign table_full  = (used_ff >= SW'(REC_CAP));
   assign slot_dec    = slot_rd_data - SW'(1);
   assign key_match   = (rec_rd_data.device == key_ff.device_id) &&
                        (rec_rd_data.inode == key_ff.inode_number);
   assign count_next  = (rec_rd_data.count == ikht_pkg::COUNT_MAX) ?
                        rec_rd_data.count : rec_rd_data.count + 16'd1;

   // The response index is the record number taken to ten bits.
   assign idx_sel = (state_ff == ST_SLOT_CHK) ? used_ff[RW-1:0] : rec_addr_ff;
   assign idx_ext = {{10{1'b0}}, idx_sel};

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      probe_in     = probe_ff;
      rec_addr_in  = rec_addr_ff;
      used_in      = used_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = probe_ff;
      slot_wr_data = used_ff + SW'(1);
      slot_rd_en   = 1'b0;
      rec_wr_en    = 1'b0;
      rec_wr_addr  = rec_addr_ff;
      rec_wr_data  = rec_rd_data;
      rec_rd_en    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_ff;
            slot_wr_data = '0;
            clr_in       = clr_ff + SW'(1);
            if (clr_ff == SW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_payload;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               probe_in = hash_value[SW-1:0];
               state_in = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: begin
            slot_rd_en = 1'b1;
            state_in   = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            if (slot_rd_data == '0) begin
               // An empty slot ends the probe: the key is new. The table never
               // fills past half, so an empty slot is always found.
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (table_full) begin
                     rsp_in        = '0;
                     rsp_in.status = ikht_pkg::STATUS_FULL;
                  end else begin
                     slot_wr_en              = 1'b1;
                     rec_wr_en               = 1'b1;
                     rec_wr_addr             = used_ff[RW-1:0];
                     rec_wr_data.device      = key_ff.device_id;
                     rec_wr_data.inode       = key_ff.inode_number;
                     rec_wr_data.first_path  = key_ff.path_id;
                     rec_wr_data.count       = 16'd1;
                     used_in                 = used_ff + SW'(1);
                     rsp_in.record_index     = idx_ext[9:0];
                     rsp_in.is_new           = 1'b1;
                     rsp_in.prior_count      = '0;
                     rsp_in.first_path       = key_ff.path_id;
                     rsp_in.status           = ikht_pkg::STATUS_OK;
                  end
               end
            end else begin
               rec_rd_en   = 1'b1;
               rec_addr_in = slot_dec[RW-1:0];
               state_in    = ST_REC_CHK;
            end
         end
         ST_REC_CHK: begin
            if (key_match) begin
               if (rsp_free) begin
                  rsp_load                = 1'b1;
                  state_in                = ST_IDLE;
                  rec_wr_en               = 1'b1;
                  rec_wr_data.count       = count_next;
                  rsp_in.record_index     = idx_ext[9:0];
                  rsp_in.is_new           = 1'b0;
                  rsp_in.prior_count      = rec_rd_data.count;
                  rsp_in.first_path       = rec_rd_data.first_path;
                  rsp_in.status           = ikht_pkg::STATUS_OK;
               end
            end else begin
               probe_in = probe_ff + SW'(1);
               state_in = ST_SLOT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      probe_ff    <= probe_in;
      rec_addr_ff <= rec_addr_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A probe may only claim a slot that it has just read as empty.
   a_claim_empty_slot: assert property (@(posedge clock) disable iff (reset)
      (slot_wr_en && (state_ff == ST_SLOT_CHK)) |-> (slot_rd_data == '0))
      else $error("slot claimed that was not empty");

   // The record count never passes half the slot table.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SW'(REC_CAP))
      else $error("record count beyond capacity");

   // Each new record advances the allocation count by exactly one.
   a_new_record_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.is_new) |=> (used_ff == $past(used_ff) + SW'(1)))
      else $error("new record did not advance allocation");

   // A refused key is reported only when the records are at capacity.
   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_in.status == ikht_pkg::STATUS_FULL)) |-> table_full)
      else $error("full status with free records");

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   // The hash unit finishes only while the sequencer waits for it.
   a_hash_in_step: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("hash finished outside the hash phase");

endmodule

@@ src/ikht_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ikht_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ikht_fnv_hash.sv @@
// Two-fold 64-bit FNV-1a hash built around one shared 32x32 multiplier.
// Depends on ikht_pkg for the FNV constants.
module ikht_fnv_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] device_id,
   input  logic [63:0] inode_number,
   output logic        done,
   output logic [63:0] hash
);

   // Each fold multiplies by the prime modulo 2^64 as three partial products:
   // lo*P_lo, then hi*P_lo and lo*P_hi added into the upper word.
   // The inode input must hold steady while the unit is busy.
   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] op_ff, op_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  sub;
   logic        fold;
   logic [31:0] mul_a;
   logic [31:0] mul_b;

   assign sub  = step_ff[1:0];
   assign fold = step_ff[2];

   assign mul_a   = (sub == 2'd1) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b   = (sub == 2'd2) ? ikht_pkg::PRIME_HI : ikht_pkg::PRIME_LO;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (sub) inside
         2'd1: begin
            acc_in = prod_ff;
         end
         2'd2, 2'd3: begin
            acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      op_in     = op_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         op_in     = ikht_pkg::FNV_BASIS ^ {32'd0, device_id};
      end else if (active_ff) begin
         step_in = step_ff + 3'd1;
         if (sub == 2'd3) begin
            if (!fold) begin
               op_in = acc_in ^ inode_number;
            end else begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      op_ff   <= op_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign hash = acc_ff;

endmodule
